// ===== rtl/core/frce_pkg.sv =====
// ----------------------------------------------------------------------------
// frce_pkg: shared types and constants for the free range carver
// Register indexes, item kinds, sequencer step codes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package frce_pkg;

  localparam int ADDR_W = 32;
  localparam logic [ADDR_W-1:0] ADDR_MAX = 32'hFFFF_FFFF;

  // Watermark rounding granule, a power of two.
  localparam logic [ADDR_W:0] BLOCK_BYTES = 33'd4096;
  localparam logic [ADDR_W:0] BLOCK_MASK  = BLOCK_BYTES - 33'd1;

  // Everything below this address is never handed out.
  localparam logic [ADDR_W-1:0] LOW_MEMORY_LIMIT = 32'h0010_0000;

  localparam int COUNT_W   = 4;
  localparam int SLOT_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WATERMARK_TOP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOOTINFO_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOOTINFO_END   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_COUNT   = 3'd5;

  localparam logic OP_CARVE = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Sequencer steps; also the controller state codes.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] ST_LOWER  = 3'd1;
  localparam logic [STEP_W-1:0] ST_KERNEL = 3'd2;
  localparam logic [STEP_W-1:0] ST_WMARK  = 3'd3;
  localparam logic [STEP_W-1:0] ST_BOOT   = 3'd4;
  localparam logic [STEP_W-1:0] ST_MODS   = 3'd5;
  localparam logic [STEP_W-1:0] ST_TAIL   = 3'd6;
  localparam logic [STEP_W-1:0] ST_FLUSH  = 3'd7;

  localparam int S_TDATA_W = 136;
  localparam int M_TDATA_W = 64;

  typedef struct packed {
    logic              carve_load;
    logic              module_load;
    logic [STEP_W-1:0] step;
    logic              go;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic push;
    logic out_free;
    logic mod_none;
    logic mod_last;
  } status_t;

endpackage

// ===== rtl/core/frce_ctrl.sv =====
// ----------------------------------------------------------------------------
// frce_ctrl: carve sequencer
// Steps one carve request through the exclusion stages, one per cycle,
// stalling whenever a finished piece cannot move to the output register.
// ----------------------------------------------------------------------------
module frce_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tuser,
  output logic               s_tready,
  input  frce_pkg::status_t  status,
  output frce_pkg::cmd_t     cmd
);

  logic [frce_pkg::STEP_W-1:0] state;
  logic [frce_pkg::STEP_W-1:0] state_next;

  always_comb begin
    state_next      = state;
    cmd.carve_load  = 1'b0;
    cmd.module_load = 1'b0;
    cmd.step        = state;
    cmd.go          = (state != frce_pkg::ST_IDLE) && (!status.push || status.out_free);
    case (state)
      frce_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == frce_pkg::OP_LOAD) begin
            cmd.module_load = 1'b1;
          end else begin
            cmd.carve_load = 1'b1;
            state_next     = frce_pkg::ST_LOWER;
          end
        end
      end
      frce_pkg::ST_LOWER: begin
        state_next = status.drop ? frce_pkg::ST_IDLE : frce_pkg::ST_KERNEL;
      end
      frce_pkg::ST_KERNEL: begin
        state_next = frce_pkg::ST_WMARK;
      end
      frce_pkg::ST_WMARK: begin
        state_next = frce_pkg::ST_BOOT;
      end
      frce_pkg::ST_BOOT: begin
        if (cmd.go) begin
          state_next = status.mod_none ? frce_pkg::ST_TAIL : frce_pkg::ST_MODS;
        end
      end
      frce_pkg::ST_MODS: begin
        if (cmd.go && status.mod_last) begin
          state_next = frce_pkg::ST_TAIL;
        end
      end
      frce_pkg::ST_TAIL: begin
        if (cmd.go) begin
          state_next = frce_pkg::ST_FLUSH;
        end
      end
      frce_pkg::ST_FLUSH: begin
        if (cmd.go) begin
          state_next = frce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = frce_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frce_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == frce_pkg::ST_IDLE);

endmodule

// ===== rtl/core/frce_dp.sv =====
// ----------------------------------------------------------------------------
// frce_dp: carve datapath
// Holds configuration, the module window table, the working cursor, one
// pending piece and the output register.
// ----------------------------------------------------------------------------
module frce_dp #(
  parameter int MAX_MODULES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  frce_pkg::cmd_t                      cmd,
  output frce_pkg::status_t                   status,
  input  logic                                cfg_we,
  input  logic [frce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [frce_pkg::ADDR_W-1:0]         cfg_data,
  input  logic [frce_pkg::S_TDATA_W-1:0]      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [frce_pkg::ADDR_W-1:0]         free_start,
  output logic [frce_pkg::ADDR_W-1:0]         out_end,
  output logic                                out_last
);

  localparam int IDX_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
  localparam int CNT_W = $clog2(MAX_MODULES + 1);

  // configuration
  logic [31:0] kernel_start;
  logic [31:0] kernel_end;
  logic [31:0] watermark_top;
  logic [31:0] bootinfo_start;
  logic [31:0] bootinfo_end;
  logic [frce_pkg::COUNT_W-1:0] module_count;
  logic [31:0] wm_round;

  // module window table
  logic [31:0] mws [MAX_MODULES];
  logic [31:0] mwe [MAX_MODULES];

  // working state
  logic [31:0]      cur;
  logic [31:0]      rend;
  logic [CNT_W-1:0] idx;
  logic             pend_valid;
  logic [31:0]      pend_start;
  logic [31:0]      pend_end;

  // input fields
  logic [31:0]                 in_rs;
  logic [31:0]                 in_len;
  logic [frce_pkg::SLOT_W-1:0] in_slot;
  logic [31:0]                 in_base;
  logic [31:0]                 in_limit;
  logic                        slot_ok;
  logic [32:0]                 end_sum;
  logic [32:0]                 wm_sum;

  logic [4:0]       cnt_wide;
  logic [CNT_W-1:0] cnt_eff;

  logic [31:0] win_s;
  logic [31:0] win_e;
  logic        hit;
  logic        ahead;
  logic        emit;
  logic [31:0] piece_end;
  logic        flush;
  logic        push;

  assign in_rs    = in_data[31:0];
  assign in_len   = in_data[63:32];
  assign in_slot  = in_data[66:64];
  assign in_base  = in_data[98:67];
  assign in_limit = in_data[130:99];
  assign slot_ok  = 5'(in_slot) < 5'(MAX_MODULES);
  assign end_sum  = {1'b0, in_rs} + {1'b0, in_len};

  assign wm_sum = ({1'b0, watermark_top} + frce_pkg::BLOCK_MASK) & ~frce_pkg::BLOCK_MASK;

  assign cnt_wide = (5'(module_count) > 5'(MAX_MODULES)) ? 5'(MAX_MODULES) : 5'(module_count);
  assign cnt_eff  = cnt_wide[CNT_W-1:0];

  always_comb begin
    if (cmd.step == frce_pkg::ST_BOOT) begin
      win_s = bootinfo_start;
      win_e = bootinfo_end;
    end else begin
      win_s = mws[IDX_W'(idx)];
      win_e = mwe[IDX_W'(idx)];
    end
  end

  assign hit   = (cur < win_e) && (rend > win_s);
  assign ahead = cur < win_s;

  always_comb begin
    emit      = 1'b0;
    piece_end = win_s;
    case (cmd.step)
      frce_pkg::ST_BOOT, frce_pkg::ST_MODS: begin
        emit = hit && ahead;
      end
      frce_pkg::ST_TAIL: begin
        emit      = cur < rend;
        piece_end = rend;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign flush = (cmd.step == frce_pkg::ST_FLUSH);
  assign push  = pend_valid && (emit || flush);

  assign status.drop     = rend <= frce_pkg::LOW_MEMORY_LIMIT;
  assign status.push     = push;
  assign status.out_free = !out_valid || out_ready;
  assign status.mod_none = (cnt_eff == '0);
  assign status.mod_last = (idx == cnt_eff - CNT_W'(1));

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_start   <= '0;
      kernel_end     <= '0;
      watermark_top  <= '0;
      bootinfo_start <= '0;
      bootinfo_end   <= '0;
      module_count   <= '0;
      idx            <= '0;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          frce_pkg::REG_KERNEL_START:   kernel_start   <= cfg_data;
          frce_pkg::REG_KERNEL_END:     kernel_end     <= cfg_data;
          frce_pkg::REG_WATERMARK_TOP:  watermark_top  <= cfg_data;
          frce_pkg::REG_BOOTINFO_START: bootinfo_start <= cfg_data;
          frce_pkg::REG_BOOTINFO_END:   bootinfo_end   <= cfg_data;
          frce_pkg::REG_MODULE_COUNT:   module_count   <= cfg_data[frce_pkg::COUNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.go) begin
        if (cmd.step == frce_pkg::ST_BOOT) begin
          idx <= '0;
        end else if (cmd.step == frce_pkg::ST_MODS) begin
          idx <= idx + CNT_W'(1);
        end
        if (emit) begin
          pend_valid <= 1'b1;
        end else if (flush) begin
          pend_valid <= 1'b0;
        end
      end
      if (cmd.go && push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    wm_round <= wm_sum[32] ? frce_pkg::ADDR_MAX : wm_sum[31:0];
    if (cmd.module_load && slot_ok) begin
      mws[IDX_W'(in_slot)] <= in_base;
      mwe[IDX_W'(in_slot)] <= in_limit;
    end
    if (cmd.carve_load) begin
      cur  <= in_rs;
      rend <= end_sum[32] ? frce_pkg::ADDR_MAX : end_sum[31:0];
    end
    if (cmd.go) begin
      case (cmd.step)
        frce_pkg::ST_LOWER: begin
          if (cur < frce_pkg::LOW_MEMORY_LIMIT) begin
            cur <= frce_pkg::LOW_MEMORY_LIMIT;
          end
        end
        frce_pkg::ST_KERNEL: begin
          if ((cur < kernel_end) && (rend > kernel_start)) begin
            cur <= kernel_end;
          end
        end
        frce_pkg::ST_WMARK: begin
          if (cur < wm_round) begin
            cur <= wm_round;
          end
        end
        frce_pkg::ST_BOOT, frce_pkg::ST_MODS: begin
          if (hit) begin
            cur <= win_e;
          end
        end
        default: begin
        end
      endcase
      if (emit) begin
        pend_start <= cur;
        pend_end   <= piece_end;
      end
      if (push) begin
        free_start <= pend_start;
        out_end    <= pend_end;
        out_last   <= flush;
      end
    end
  end

  a_piece_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (free_start < out_end))
    else $error("empty free piece on output");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (cmd.step == frce_pkg::ST_IDLE) |-> !pend_valid)
    else $error("piece left pending after carve");

  a_cursor_rises: assert property (@(posedge clk) disable iff (rst)
    (cmd.go && cmd.step != frce_pkg::ST_IDLE && cmd.step != frce_pkg::ST_LOWER)
      |=> (cur >= $past(cur)))
    else $error("carve cursor moved backwards");

  a_flush_drains: assert property (@(posedge clk) disable iff (rst)
    (cmd.go && cmd.step == frce_pkg::ST_FLUSH) |=> !pend_valid)
    else $error("pending piece survived flush");

endmodule

// ===== rtl/core/free_range_carve_exclusions.sv =====
// ----------------------------------------------------------------------------
// free_range_carve_exclusions: free physical range carver
// Carves the low megabyte, kernel image, watermark, boot-info window and
// module windows out of a usable range and streams the free pieces.
// ----------------------------------------------------------------------------
// Sequencing: a carve request holds the input while the sequencer steps
//   through lower, kernel, watermark, boot-info, one step per module window
//   (at most MAX_MODULES), tail and flush, one step per cycle but for output
//   stalls; a carve whose range ends at or below the low megabyte ends after
//   the lower step; a load request is taken without leaving idle.
// Output: the final piece leaves the pending stage at the flush step; an
//   earlier piece waits there until the step that finds the next piece.
// Reset: synchronous rst clears the sequencer, pending and output valids and
//   all configuration registers; the module window table is not cleared.
// ----------------------------------------------------------------------------
module free_range_carve_exclusions #(
  parameter int MAX_MODULES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream: one request per handshake
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata, lowest bit up: region_start[31:0], region_length[31:0],
  //   module_slot[2:0], module_base[31:0], module_limit[31:0], zero pad[4:0]
  input  logic [frce_pkg::S_TDATA_W-1:0]  s_tdata,
  // s_tuser: op (0 carve, 1 load a module window)
  input  logic                            s_tuser,
  // output stream: one free piece per handshake
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata, lowest bit up: free_start[31:0], free_end[31:0]
  output logic [frce_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                            m_tlast,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [frce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frce_pkg::ADDR_W-1:0]     cfg_data
);

  frce_pkg::cmd_t    cmd;
  frce_pkg::status_t status;

  logic [frce_pkg::ADDR_W-1:0] free_start;
  logic [frce_pkg::ADDR_W-1:0] out_end;

  // Sequencer: takes requests only between carves; a load request is
  // written straight into the table in the accepting cycle.
  frce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: cursor, window compares, pending piece and output register.
  // A found piece waits in the pending stage until the next one is found or
  // the carve ends, which settles its last flag.
  frce_dp #(
    .MAX_MODULES (MAX_MODULES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_data    (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .free_start (free_start),
    .out_end    (out_end),
    .out_last   (m_tlast)
  );

  assign m_tdata = {out_end, free_start};

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the free range carver
// Drives carve and module-window load requests through the input stream,
// predicts every free piece in the bench itself and compares each piece that
// leaves the output stream, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  // Bench-side view of the carver's fixed constants.
  localparam logic [32:0] GRANULE     = 33'd4096;
  localparam logic [31:0] LOW_LIMIT   = 32'h0010_0000;
  localparam int          TABLE_SIZE  = 8;
  // A carve holds the input until its sequencer steps are done; once every
  // predicted piece has left, allow a further margin before touching the registers.
  localparam int          SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          PHASES        = 6;
  localparam int          PHASE_ITEMS   = 15;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        last;
  } piece_t;

  typedef enum int {RX_STREAM, RX_RANDOM, RX_STARVED, RX_TOGGLE} rx_mode_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [frce_pkg::S_TDATA_W-1:0]   s_tdata = '0;
  logic                             s_tuser = frce_pkg::OP_CARVE;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [frce_pkg::M_TDATA_W-1:0]   m_tdata;
  logic                             m_tlast;
  logic                             cfg_we = 1'b0;
  logic [frce_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [frce_pkg::ADDR_W-1:0]      cfg_data = '0;

  // Predictor copy of the configuration and the module window entries.
  logic [31:0] kernel_lo, kernel_hi, watermark, boot_lo, boot_hi;
  logic [3:0]  window_count;
  logic [31:0] win_lo [TABLE_SIZE];
  logic [31:0] win_hi [TABLE_SIZE];

  piece_t      pending_pieces[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int          burst_left  = 0;
  bit          gaps_on     = 1'b1;
  rx_mode_t    rx_mode     = RX_STREAM;
  int          rx_span     = 0;

  free_range_carve_exclusions dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog: a hung carver must not hold the run for ever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pieces outstanding", cycle_count,
               pending_pieces.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver back-pressure: switch between free flow, coin-flip stalls,
  // long starvation and strict toggling, each held for a random span.
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(8, 60);
    end
    rx_span--;
    case (rx_mode)
      RX_STREAM:  m_tready <= 1'b1;
      RX_RANDOM:  m_tready <= 1'($urandom_range(0, 1));
      RX_STARVED: m_tready <= ($urandom_range(0, 5) == 0);
      default:    m_tready <= ~m_tready;
    endcase
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40)
      $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Compare every piece that leaves against the oldest prediction.
  always @(posedge clk) begin : check_piece
    piece_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pieces.size() == 0) begin
        report_mismatch($sformatf("unexpected piece %h..%h last %b",
                                  m_tdata[31:0], m_tdata[63:32], m_tlast));
      end else begin
        want = pending_pieces.pop_front();
        if (m_tdata[31:0] !== want.lo)
          report_mismatch($sformatf("free_start %h, want %h", m_tdata[31:0], want.lo));
        if (m_tdata[63:32] !== want.hi)
          report_mismatch($sformatf("free_end %h, want %h", m_tdata[63:32], want.hi));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last %b, want %b on piece %h..%h",
                                    m_tlast, want.last, want.lo, want.hi));
      end
    end
  end

  // Work out the free pieces of one carve and queue them in emission order.
  function automatic void predict_carve(input logic [31:0] rs, input logic [31:0] len);
    logic [32:0] sum;
    logic [32:0] rounded;
    logic [31:0] top, cur, wm;
    int          n_win;
    piece_t      found[$];
    piece_t      p;
    sum = {1'b0, rs} + {1'b0, len};
    top = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (top <= LOW_LIMIT)
      return;
    cur = (rs < LOW_LIMIT) ? LOW_LIMIT : rs;
    if (cur < kernel_hi && top > kernel_lo)
      cur = kernel_hi;
    // Round the watermark up to a whole block, saturating past the top.
    rounded = ({1'b0, watermark} + GRANULE - 33'd1) & ~(GRANULE - 33'd1);
    wm = rounded[32] ? 32'hFFFF_FFFF : rounded[31:0];
    if (cur < wm)
      cur = wm;
    if (cur < boot_hi && top > boot_lo) begin
      if (cur < boot_lo) begin
        p = '{lo: cur, hi: boot_lo, last: 1'b0};
        found.push_back(p);
      end
      cur = boot_hi;
    end
    n_win = (window_count > TABLE_SIZE) ? TABLE_SIZE : int'(window_count);
    for (int i = 0; i < n_win; i++) begin
      if (cur < win_hi[i] && top > win_lo[i]) begin
        if (cur < win_lo[i]) begin
          p = '{lo: cur, hi: win_lo[i], last: 1'b0};
          found.push_back(p);
        end
        cur = win_hi[i];
      end
    end
    if (cur < top) begin
      p = '{lo: cur, hi: top, last: 1'b0};
      found.push_back(p);
    end
    for (int i = 0; i < found.size(); i++) begin
      p = found[i];
      p.last = (i == found.size() - 1);
      pending_pieces.push_back(p);
    end
  endfunction

  // Send one request; when gaps are on, requests go in bursts with idle gaps between bursts.
  task automatic send_request(input logic op, input logic [31:0] rs, input logic [31:0] len,
                              input logic [2:0] slot, input logic [31:0] base,
                              input logic [31:0] limit);
    int gap;
    if (burst_left <= 0) begin
      burst_left = gaps_on ? $urandom_range(1, 8) : 1000;
      if (gaps_on && s_tvalid) begin
        gap = $urandom_range(0, 5);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'b0, limit, base, slot, len, rs};
    do @(posedge clk); while (!s_tready);
    if (op == frce_pkg::OP_LOAD) begin
      if (slot < TABLE_SIZE) begin
        win_lo[slot] = base;
        win_hi[slot] = limit;
      end
    end else begin
      predict_carve(rs, len);
    end
  endtask

  task automatic carve(input logic [31:0] rs, input logic [31:0] len);
    send_request(frce_pkg::OP_CARVE, rs, len, 3'($urandom), $urandom, $urandom);
  endtask

  task automatic load_window(input logic [2:0] slot, input logic [31:0] base,
                             input logic [31:0] limit);
    send_request(frce_pkg::OP_LOAD, $urandom, $urandom, slot, base, limit);
  endtask

  // Drop valid, drain every predicted piece and let the sequencer go idle.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pieces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [frce_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      frce_pkg::REG_KERNEL_START:   kernel_lo    = val;
      frce_pkg::REG_KERNEL_END:     kernel_hi    = val;
      frce_pkg::REG_WATERMARK_TOP:  watermark    = val;
      frce_pkg::REG_BOOTINFO_START: boot_lo      = val;
      frce_pkg::REG_BOOTINFO_END:   boot_hi      = val;
      frce_pkg::REG_MODULE_COUNT:   window_count = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_exclusions(input logic [31:0] k_lo, input logic [31:0] k_hi,
                                input logic [31:0] wm, input logic [31:0] b_lo,
                                input logic [31:0] b_hi, input logic [3:0] count);
    write_reg(frce_pkg::REG_KERNEL_START, k_lo);
    write_reg(frce_pkg::REG_KERNEL_END, k_hi);
    write_reg(frce_pkg::REG_WATERMARK_TOP, wm);
    write_reg(frce_pkg::REG_BOOTINFO_START, b_lo);
    write_reg(frce_pkg::REG_BOOTINFO_END, b_hi);
    write_reg(frce_pkg::REG_MODULE_COUNT, {28'd0, count});
  endtask

  // Addresses cluster around the low tens of megabytes so that windows,
  // kernel and ranges overlap often; the rest spans the whole space.
  function automatic logic [31:0] pick_addr();
    int unsigned sel;
    logic [31:0] a;
    sel = $urandom_range(0, 99);
    a = $urandom_range(32'h000C_0000, 32'h0180_0000);
    if (sel < 40)
      return a & 32'hFFFF_F000;
    if (sel < 70)
      return a;
    if (sel < 88)
      return $urandom;
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return LOW_LIMIT;
      2:       return 32'hFFFF_F000;
      3:       return 32'hFFFF_F001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60)
      return $urandom_range(0, 32'h0080_0000);
    if (sel < 85)
      return $urandom;
    case ($urandom_range(0, 2))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_end(input logic [31:0] lo);
    if ($urandom_range(0, 9) < 7)
      return lo + $urandom_range(0, 32'h0040_0000);
    return pick_addr();
  endfunction

  function automatic logic [31:0] pick_reg(input logic [31:0] typical);
    case ($urandom_range(0, 6))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return typical;
    endcase
  endfunction

  // Reset configuration: only the low megabyte is carved out.
  task automatic test_low_memory();
    carve(32'h0000_0000, 32'h0000_0000);
    carve(32'h0000_0000, LOW_LIMIT);                 // end lands on the limit
    carve(32'h000F_FFFF, 32'h0000_0001);
    carve(32'h0000_0000, 32'h0010_0001);             // one byte above the limit
    carve(32'hFFFF_FFFF, 32'hFFFF_FFFF);             // end saturates, nothing free
    carve(32'h8000_0000, 32'hFFFF_FFFF);             // end saturates
    carve(32'h0000_0000, 32'hFFFF_FFFF);
    settle();
  endtask

  // Fill every slot before any carve can look at the windows.
  task automatic test_window_load();
    logic [31:0] base;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      base = 32'h0040_0000 + i * 32'h0020_0000;
      case (i)
        5:       load_window(i[2:0], 32'h0000_0000, 32'h0000_0000);  // empty window
        6:       load_window(i[2:0], 32'h0030_0000, 32'h0038_0000);  // already passed
        7:       load_window(i[2:0], 32'hFFFF_F000, 32'hFFFF_FFFF);
        default: load_window(i[2:0], base, base + 32'h0010_0000);
      endcase
    end
    settle();
  endtask

  task automatic test_exclusions();
    // Count above the table size is clamped to eight windows.
    set_exclusions(32'h0010_0000, 32'h0020_0000, 32'h0020_0001,
                   32'h0028_0000, 32'h0030_0000, 4'd15);
    carve(32'h0000_0000, 32'hFFFF_FFFF);
    carve(32'h0015_0000, 32'h0001_0000);             // swallowed by the kernel
    // Lay windows so that every one leaves a piece before it: ten pieces.
    load_window(3'd5, 32'h00E0_0000, 32'h00E8_0000);
    load_window(3'd6, 32'h00F0_0000, 32'h00F8_0000);
    load_window(3'd7, 32'h0100_0000, 32'h0108_0000);
    carve(32'h0000_0000, 32'h0200_0000);
    settle();
    // Watermark rounding runs past the top and saturates.
    write_reg(frce_pkg::REG_WATERMARK_TOP, 32'hFFFF_F001);
    carve(32'h0020_0000, 32'hFFFF_FFFF);
    settle();
    write_reg(frce_pkg::REG_WATERMARK_TOP, 32'hFFFF_F000);
    write_reg(frce_pkg::REG_MODULE_COUNT, 32'd8);
    carve(32'h0000_0000, 32'hFFFF_FFFF);
    settle();
    set_exclusions(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
    carve(32'hFFFF_0000, 32'h0000_FFFF);
    settle();
  endtask

  // Random phases: fresh exclusions each time, mostly carves with the odd
  // window reload mixed in; one phase runs the sender flat out.
  task automatic test_random_traffic();
    logic [31:0] k_lo, b_lo, base;
    for (int ph = 0; ph < PHASES; ph++) begin
      gaps_on = (ph != 2);
      k_lo = pick_reg(pick_addr());
      b_lo = pick_reg(pick_addr());
      set_exclusions(k_lo, pick_reg(pick_end(k_lo)), pick_reg(pick_addr()),
                     b_lo, pick_reg(pick_end(b_lo)), 4'($urandom_range(0, 15)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          base = pick_addr();
          load_window(3'($urandom_range(0, TABLE_SIZE - 1)), base,
                      ($urandom_range(0, 9) < 8) ? base + $urandom_range(0, 32'h0018_0000)
                                                  : pick_addr());
        end else begin
          carve(pick_addr(), pick_length());
        end
      end
      settle();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    kernel_lo    = '0;
    kernel_hi    = '0;
    watermark    = '0;
    boot_lo      = '0;
    boot_hi      = '0;
    window_count = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    test_low_memory();
    test_window_load();
    test_exclusions();
    test_random_traffic();

    settle();
    if (pending_pieces.size() != 0)
      report_mismatch($sformatf("%0d predicted pieces never arrived", pending_pieces.size()));
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/frce_pkg.sv
rtl/core/frce_ctrl.sv
rtl/core/frce_dp.sv
rtl/core/free_range_carve_exclusions.sv
sim/tb.sv
